### design/bce_pkg.sv
// Shared types, constants and sequencer states for the binary cross-entropy block.
// No dependencies; every other design file imports this package.
package bce_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_ELEMENTS = 65536;
    localparam int CNT_W        = 17;
    localparam int DIV_W        = 64;
    localparam int DVS_W        = 47;
    localparam int FRAC_CNT_W   = $clog2(FRAC_BITS);
    localparam int DIV_CNT_W    = $clog2(DIV_W);

    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] MEAN_MAX = 24'hFF_FFFF;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    typedef enum logic [1:0] {
        REG_ELEMENT_COUNT = 2'd0,
        REG_UPSTREAM_GRAD = 2'd1,
        REG_GRAD_ENABLE   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_COST = 1'b0,
        KIND_GRAD = 1'b1
    } kind_t;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        pred_prob;
        logic [16:0]        truth_prob;
        logic signed [31:0] grad_in;
    } req_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [23:0]        mean_cost;
        logic signed [31:0] grad_out;
        logic               saturated;
    } rsp_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOGP_GO,
        ST_LOGP_RUN,
        ST_LNP,
        ST_LOGQ_RUN,
        ST_LNQ,
        ST_COST1,
        ST_COST2,
        ST_COST3,
        ST_BWD1,
        ST_BWD2,
        ST_BWD3,
        ST_BWD4,
        ST_BWD5,
        ST_DIV_RUN,
        ST_FINISH
    } state_t;

endpackage

### design/binary_cross_entropy_loss_grad.sv
// Binary cross-entropy cost and gradient, one word at a time under a sequencer.
// Forward word: two log runs, then the cost steps; a word that closes the pass also starts
// the divide of the sum, and its mean appears once the divide is done.
// Backward word: the products of ST_BWD1 to ST_BWD5, then the bit-serial divider gives the result.
// A new word is taken only in ST_IDLE, once the last is through; ST_FINISH holds while rsp is full.
// rst_n is asynchronous, active low; it clears the sum, the count and the registers
// (element_count 1, upstream_gradient 1.0, grad_enable 1). Depends on bce_pkg, bce_log, bce_div.
module binary_cross_entropy_loss_grad
    import bce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [CNT_W-1:0] elem_cnt_reg;
    logic [31:0]      upstream_reg;
    logic             grad_en_reg;

    // Running forward state.
    logic [47:0]      cost_sum_reg, cost_sum_next;
    logic [CNT_W-1:0] fwd_cnt_reg, fwd_cnt_next;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    // Operands of the current word.
    logic [15:0]        p_reg, p_next;
    logic [15:0]        q_reg, q_next;
    logic [16:0]        t_reg, t_next;
    logic [16:0]        u_reg, u_next;
    logic signed [31:0] g_reg, g_next;

    // Intermediate results.
    logic [19:0] lp_reg, lp_next;
    logic [19:0] lq_reg, lq_next;
    logic [63:0] acc_reg, acc_next;
    logic [32:0] dmag_reg, dmag_next;
    logic        dneg_reg, dneg_next;
    logic        msat_reg, msat_next;
    logic [63:0] prod_reg;

    // Output register.
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_word_reg, rsp_word_next;

    // Shared multiplier.
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic             log_start, log_done;
    logic [15:0]      log_x;
    logic [20:0]      log_l2;
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quotient;
    logic [DVS_W-1:0] div_divisor;

    logic [CNT_W-1:0] n_eff;
    logic [15:0]      p_clamp;
    logic [16:0]      t_clamp;
    logic [63:0]      ln_round;
    logic [63:0]      cost_full;
    logic [47:0]      cost_elem;
    logic [48:0]      sum_wide;
    logic [47:0]      sum_sat;
    logic [CNT_W-1:0] cnt_inc;
    logic [31:0]      umag;
    logic             uneg;
    logic [33:0]      q_clip;
    logic signed [35:0] grad_sum;
    logic [23:0]      mean_val;

    bce_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .x     (log_x),
        .done  (log_done),
        .l2    (log_l2)
    );

    bce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Effective element count: zero acts as one, large values clip to the maximum.
    always_comb
    begin
        if (elem_cnt_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (elem_cnt_reg > CNT_W'(MAX_ELEMENTS))
        begin
            n_eff = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_eff = elem_cnt_reg;
        end
    end

    assign p_clamp = (req_word.pred_prob == 16'd0) ? 16'd1 : req_word.pred_prob;
    assign t_clamp = (req_word.truth_prob > ONE_Q16) ? ONE_Q16 : req_word.truth_prob;

    assign uneg = upstream_reg[31];
    assign umag = uneg ? (~upstream_reg + 32'd1) : upstream_reg;

    assign mul_p = 66'(mul_a) * 66'(mul_b);

    // Natural log from the base-2 log, rounded half up.
    assign ln_round = prod_reg + 64'h8000_0000;

    // Element cost: T*L(p) + U*L(1-p), rounded half up to Q.16.
    assign cost_full = acc_reg + prod_reg + 64'(1 << (FRAC_BITS - 1));
    assign cost_elem = cost_full[FRAC_BITS+47:FRAC_BITS];
    assign sum_wide  = {1'b0, cost_sum_reg} + {1'b0, cost_elem};
    assign sum_sat   = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
    assign cnt_inc   = (fwd_cnt_reg == '1) ? fwd_cnt_reg : fwd_cnt_reg + 1'b1;

    // Finishing arithmetic on the divider quotient.
    assign q_clip   = (div_quotient > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_quotient[33:0];
    assign grad_sum = (dneg_reg != uneg) ? (36'(g_reg) - $signed({2'b00, q_clip}))
                                         : (36'(g_reg) + $signed({2'b00, q_clip}));
    assign mean_val = (div_quotient > 64'(MEAN_MAX)) ? MEAN_MAX : div_quotient[23:0];

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        g_next         = g_reg;
        lp_next        = lp_reg;
        lq_next        = lq_reg;
        acc_next       = acc_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        msat_next      = msat_reg;
        cost_sum_next  = cost_sum_reg;
        fwd_cnt_next   = fwd_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_word_next  = rsp_word_reg;
        req_ready      = 1'b0;
        log_start      = 1'b0;
        log_x          = p_reg;
        div_start      = 1'b0;
        div_dividend   = acc_reg;
        div_divisor    = prod_reg[DVS_W-1:0];
        mul_a          = 33'(log_l2);
        mul_b          = 33'(LN2_Q32);

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    p_next = p_clamp;
                    q_next = 16'(ONE_Q16 - 17'(p_clamp));
                    t_next = t_clamp;
                    u_next = ONE_Q16 - t_clamp;
                    g_next = req_word.grad_in;
                    if (req_word.req_type == KIND_COST)
                    begin
                        kind_next  = KIND_COST;
                        state_next = ST_LOGP_GO;
                    end
                    else if (grad_en_reg)
                    begin
                        kind_next  = KIND_GRAD;
                        state_next = ST_BWD1;
                    end
                end
            end
            ST_LOGP_GO:
            begin
                log_start  = 1'b1;
                log_x      = p_reg;
                state_next = ST_LOGP_RUN;
            end
            ST_LOGP_RUN:
            begin
                if (log_done)
                begin
                    state_next = ST_LNP;
                end
            end
            ST_LNP:
            begin
                lp_next    = ln_round[51:32];
                log_start  = 1'b1;
                log_x      = q_reg;
                state_next = ST_LOGQ_RUN;
            end
            ST_LOGQ_RUN:
            begin
                if (log_done)
                begin
                    state_next = ST_LNQ;
                end
            end
            ST_LNQ:
            begin
                lq_next    = ln_round[51:32];
                state_next = ST_COST1;
            end
            ST_COST1:
            begin
                mul_a      = 33'(t_reg);
                mul_b      = 33'(lp_reg);
                state_next = ST_COST2;
            end
            ST_COST2:
            begin
                acc_next   = prod_reg;
                mul_a      = 33'(u_reg);
                mul_b      = 33'(lq_reg);
                state_next = ST_COST3;
            end
            ST_COST3:
            begin
                if (cnt_inc >= n_eff)
                begin
                    // Pass complete: divide the sum and start a fresh pass.
                    div_start     = 1'b1;
                    div_dividend  = 64'(sum_sat) + 64'(n_eff >> 1);
                    div_divisor   = DVS_W'(n_eff);
                    cost_sum_next = '0;
                    fwd_cnt_next  = '0;
                    state_next    = ST_DIV_RUN;
                end
                else
                begin
                    cost_sum_next = sum_sat;
                    fwd_cnt_next  = cnt_inc;
                    state_next    = ST_IDLE;
                end
            end
            ST_BWD1:
            begin
                mul_a      = 33'(u_reg);
                mul_b      = 33'(p_reg);
                state_next = ST_BWD2;
            end
            ST_BWD2:
            begin
                acc_next   = prod_reg;
                mul_a      = 33'(t_reg);
                mul_b      = 33'(q_reg);
                state_next = ST_BWD3;
            end
            ST_BWD3:
            begin
                // a = U*P in acc, b = T*Q in the product register.
                dneg_next  = prod_reg > acc_reg;
                dmag_next  = (prod_reg > acc_reg) ? 33'(prod_reg - acc_reg)
                                                  : 33'(acc_reg - prod_reg);
                mul_a      = 33'(p_reg);
                mul_b      = 33'(q_reg);
                state_next = ST_BWD4;
            end
            ST_BWD4:
            begin
                acc_next   = prod_reg;
                mul_a      = 33'(umag);
                mul_b      = dmag_reg;
                state_next = ST_BWD5;
            end
            ST_BWD5:
            begin
                // acc holds P*Q; the numerator moves into acc next.
                acc_next   = prod_reg;
                mul_a      = acc_reg[32:0];
                mul_b      = 33'(n_eff);
                state_next = ST_DIV_RUN;
                kind_next  = KIND_GRAD;
            end
            ST_DIV_RUN:
            begin
                if (kind_reg == KIND_GRAD && prod_reg[63] == 1'b0 && acc_reg != 64'd0)
                begin
                    state_next = ST_DIV_RUN;
                end
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = '0;
                    if (kind_reg == KIND_COST)
                    begin
                        rsp_word_next.result_kind = KIND_COST;
                        rsp_word_next.mean_cost   = mean_val;
                        rsp_word_next.saturated   = div_quotient > 64'(MEAN_MAX);
                    end
                    else
                    begin
                        rsp_word_next.result_kind = KIND_GRAD;
                        if (grad_sum > 36'sd2147483647)
                        begin
                            rsp_word_next.grad_out  = 32'sh7FFF_FFFF;
                            rsp_word_next.saturated = 1'b1;
                        end
                        else if (grad_sum < -36'sd2147483648)
                        begin
                            rsp_word_next.grad_out  = 32'sh8000_0000;
                            rsp_word_next.saturated = 1'b1;
                        end
                        else
                        begin
                            rsp_word_next.grad_out = grad_sum[31:0];
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The backward divide starts in the first ST_DIV_RUN state, while the denominator product is in prod_reg.
        if (state_reg == ST_DIV_RUN && kind_reg == KIND_GRAD && msat_reg)
        begin
            div_start    = 1'b1;
            div_dividend = acc_reg + 64'(prod_reg[DVS_W-1:1]);
            div_divisor  = prod_reg[DVS_W-1:0];
        end
        msat_next = (state_reg == ST_BWD5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_COST;
            cost_sum_reg  <= '0;
            fwd_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            msat_reg      <= 1'b0;
            elem_cnt_reg  <= CNT_W'(1);
            upstream_reg  <= 32'h0001_0000;
            grad_en_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cost_sum_reg  <= cost_sum_next;
            fwd_cnt_reg   <= fwd_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            msat_reg      <= msat_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ELEMENT_COUNT: elem_cnt_reg <= cfg_data[CNT_W-1:0];
                    REG_UPSTREAM_GRAD: upstream_reg <= cfg_data;
                    REG_GRAD_ENABLE:   grad_en_reg  <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        t_reg        <= t_next;
        u_reg        <= u_next;
        g_reg        <= g_next;
        lp_reg       <= lp_next;
        lq_reg       <= lq_next;
        acc_reg      <= acc_next;
        dmag_reg     <= dmag_next;
        dneg_reg     <= dneg_next;
        prod_reg     <= mul_p[63:0];
        rsp_word_reg <= rsp_word_next;
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

### design/bce_log.sv
// Serial base-2 logarithm: -log2(x/65536) in Q.16, one mantissa squaring per cycle.
// Depends on bce_pkg.
module bce_log
    import bce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] x,
    output logic        done,
    output logic [20:0] l2
);

    logic [31:0]           m_reg, m_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic [FRAC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]            e_reg, e_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [3:0]            e_lead;
    logic [63:0]           sq;
    logic [32:0]           sq_top;

    // Leading one position of the operand.
    always_comb
    begin
        e_lead = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (x[i])
            begin
                e_lead = 4'(i);
            end
        end
    end

    assign sq     = 64'(m_reg) * 64'(m_reg);
    assign sq_top = sq[63:31];

    always_comb
    begin
        m_next    = m_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        e_next    = e_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            e_next    = e_lead;
            m_next    = 32'(x) << (5'd31 - {1'b0, e_lead});
            frac_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sq_top[32])
            begin
                m_next    = sq_top[32:1];
                frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                m_next    = sq_top[31:0];
                frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == FRAC_CNT_W'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
    end

    assign done = done_reg;
    assign l2   = (21'(5'd16 - {1'b0, e_reg}) << FRAC_BITS) - 21'(frac_reg);

endmodule

### design/bce_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on bce_pkg.
module bce_div
    import bce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       diff;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits DVS_W bits.
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
